@@ sv/rational_frequency_response_eval_core_assert.svh @@
// Assertion macros shared by the checker of the frequency response core.
// Needs a signal named clock and a signal named reset in the using scope.
`ifndef RATIONAL_FREQUENCY_RESPONSE_EVAL_CORE_ASSERT_SVH
`define RATIONAL_FREQUENCY_RESPONSE_EVAL_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RFRE_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rfre assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define RFRE_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rfre assertion failed");

`endif

@@ sv/rfre_pkg.sv @@
// Types, constants and the arctangent table of the frequency response core.
// No dependencies.
package rfre_pkg;

   localparam int MUL_W  = 33;
   localparam int ACC_W  = 66;
   localparam int COEF_W = 16;
   localparam int CSR_W  = 64;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_PERIOD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ORDER     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_ORDER     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COEFFS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEN_COEFFS    = 3'd4;

   localparam logic [31:0] INV2PI_Q32   = 32'd683565276;
   localparam logic [31:0] CORDIC_ONE   = 32'h26DD3B6A;
   localparam int          CORDIC_ITERS = 16;
   localparam int          CORDIC_W     = 34;

   localparam int DIV_STEPS   = 31;
   localparam int SAT_SHIFT   = 7;
   localparam int DIV_T_W     = ACC_W + SAT_SHIFT;

   // Control word handed to the multiply-accumulate unit each cycle.
   typedef struct packed {
      logic                    first;
      logic                    neg;
      logic signed [ACC_W-1:0] init;
   } mac_op_type;

   function automatic logic [31:0] atan_turns(input logic [3:0] i);
      logic [31:0] v;
      case (i)
         4'd0:    v = 32'h20000000;
         4'd1:    v = 32'h12E4051E;
         4'd2:    v = 32'h09FB385B;
         4'd3:    v = 32'h051111D4;
         4'd4:    v = 32'h028B0D43;
         4'd5:    v = 32'h0145D7E1;
         4'd6:    v = 32'h00A2F61E;
         4'd7:    v = 32'h00517C55;
         4'd8:    v = 32'h0028BE53;
         4'd9:    v = 32'h00145F2F;
         4'd10:   v = 32'h000A2F98;
         4'd11:   v = 32'h000517CC;
         4'd12:   v = 32'h00028BE6;
         4'd13:   v = 32'h000145F3;
         4'd14:   v = 32'h0000A2FA;
         4'd15:   v = 32'h0000517D;
         default: v = 32'h0;
      endcase
      return v;
   endfunction

endpackage

@@ sv/rfre_if.sv @@
// Valid/ready channel interfaces for request and response beats.
// Depends on nothing.
interface rfre_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] omega;
   modport source (output valid, output omega, input ready);
   modport sink   (input valid, input omega, output ready);
endinterface

interface rfre_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] resp_real;
   logic signed [31:0] resp_imag;
   logic               singular;
   modport source (output valid, output resp_real, output resp_imag, output singular,
                   input ready);
   modport sink   (input valid, input resp_real, input resp_imag, input singular,
                   output ready);
endinterface

@@ sv/rfre_mac.sv @@
// Shared signed multiply-accumulate unit of the frequency response core.
// Depends on rfre_pkg.
module rfre_mac
   import rfre_pkg::*;
(
   input  logic                    clock,
   input  mac_op_type              op,
   input  logic signed [MUL_W-1:0] a,
   input  logic signed [MUL_W-1:0] b,
   output logic signed [ACC_W-1:0] acc_in
);
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] prod;

   assign prod   = a * b;
   assign acc_in = (op.first ? op.init : acc_ff) + (op.neg ? -prod : prod);

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end
endmodule

@@ sv/rfre_cordic.sv @@
// Iterative CORDIC that turns a phase in turns into cos and -sin in Q30.
// Depends on rfre_pkg.
module rfre_cordic
   import rfre_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [31:0]             ang,
   output logic                    busy,
   output logic signed [MUL_W-1:0] zr,
   output logic signed [MUL_W-1:0] zi
);
   logic                       busy_ff;
   logic [3:0]                 iter_ff;
   logic [1:0]                 quad_ff;
   logic signed [CORDIC_W-1:0] x_ff, y_ff, z_ff;
   logic signed [CORDIC_W-1:0] xs, ys, at, c, s, ns;

   assign xs = x_ff >>> iter_ff;
   assign ys = y_ff >>> iter_ff;
   assign at = CORDIC_W'(atan_turns(iter_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         iter_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         iter_ff <= '0;
      end else if (busy_ff) begin
         iter_ff <= iter_ff + 4'd1;
         if (iter_ff == 4'(CORDIC_ITERS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= CORDIC_W'(CORDIC_ONE);
         y_ff    <= '0;
         z_ff    <= CORDIC_W'(ang[29:0]);
         quad_ff <= ang[31:30];
      end else if (busy_ff) begin
         if (!z_ff[CORDIC_W-1]) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - at;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + at;
         end
      end
   end

   always_comb begin
      case (quad_ff)
         2'd0:    begin c = x_ff;  s = y_ff;  end
         2'd1:    begin c = -y_ff; s = x_ff;  end
         2'd2:    begin c = -x_ff; s = -y_ff; end
         default: begin c = y_ff;  s = -x_ff; end
      endcase
   end

   assign ns   = -s;
   assign busy = busy_ff;
   assign zr   = c[MUL_W-1:0];
   assign zi   = ns[MUL_W-1:0];
endmodule

@@ sv/rfre_div.sv @@
// Restoring divider giving a signed, saturated Q8.24 quotient one bit a cycle.
// Depends on rfre_pkg.
module rfre_div
   import rfre_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [ACC_W-1:0] num,
   input  logic [ACC_W-1:0]        den,
   output logic                    busy,
   output logic [31:0]             quot
);
   logic                 busy_ff, neg_ff, sat_ff;
   logic [4:0]           cnt_ff;
   logic [DIV_T_W-1:0]   r_ff, t_ff;
   logic [DIV_STEPS-1:0] q_ff;
   logic [ACC_W-1:0]     mag;
   logic [DIV_T_W-1:0]   t_new;
   logic [DIV_T_W:0]     r2;
   logic [31:0]          qe;

   assign mag   = num[ACC_W-1] ? ACC_W'(-num) : num;
   assign t_new = {den, SAT_SHIFT'(0)};
   assign r2    = {r_ff, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 5'd1;
         if (cnt_ff == 5'(DIV_STEPS - 1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= num[ACC_W-1];
         sat_ff <= DIV_T_W'(mag) >= t_new;
         r_ff   <= DIV_T_W'(mag);
         t_ff   <= t_new;
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (r2 >= {1'b0, t_ff}) begin
            r_ff <= DIV_T_W'(r2 - {1'b0, t_ff});
            q_ff <= {q_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            r_ff <= r2[DIV_T_W-1:0];
            q_ff <= {q_ff[DIV_STEPS-2:0], 1'b0};
         end
      end
   end

   assign qe   = {1'b0, q_ff};
   assign busy = busy_ff;
   assign quot = sat_ff ? (neg_ff ? 32'h80000000 : 32'h7FFFFFFF)
                        : (neg_ff ? -qe : qe);
endmodule

@@ sv/rational_frequency_response_eval_core.sv @@
// Frequency response core: for each request beat carrying an angular frequency omega
// (Q16.16 rad/s) it returns one response beat with B(z^-1)/A(z^-1) at
// z = exp(j*omega*Ts) in saturated Q8.24, plus a singular flag that is set, with both
// parts zero, when the denominator magnitude vanishes. One item is in flight at a time
// and the request side is not ready while it is worked on. For each item the single
// multiply-accumulate unit does three products for the phase, four for each power of
// z^-1, MAX_ORDER+1 for each of the four polynomial sums and six for the complex
// quotient terms, the CORDIC runs sixteen iterations and the two dividers run 31
// steps side by side. Singular items skip the division. A finished response waits
// in an output register, so the next request is taken while it is still unclaimed.
// The configuration registers (sample period, orders and packed Q2.13 coefficients)
// are written through the csr port; the user must write them only while the core
// is idle; the core does not enforce this. Orders above MAX_ORDER are clamped to it.
// Depends on rfre_pkg, rfre_if, rfre_mac, rfre_cordic and rfre_div.
module rational_frequency_response_eval_core
   import rfre_pkg::*;
#(
   parameter int MAX_ORDER  = 3,
   parameter int PHASE_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   rfre_req_if.sink             req,
   rfre_rsp_if.source           rsp,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PHASE  = 4'd1;
   localparam logic [3:0] S_CORDIC = 4'd2;
   localparam logic [3:0] S_POW    = 4'd3;
   localparam logic [3:0] S_SUM    = 4'd4;
   localparam logic [3:0] S_FIN    = 4'd5;
   localparam logic [3:0] S_DSTART = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_DONE   = 4'd8;

   localparam logic [1:0] ORD_MAX = 2'(MAX_ORDER);
   localparam logic signed [ACC_W-1:0] ROUND_POW = ACC_W'(64'd1 << 29);
   localparam logic signed [ACC_W-1:0] ROUND_SUM = ACC_W'(64'd1 << 18);
   localparam logic signed [MUL_W-1:0] ONE_Q30   = MUL_W'(64'd1 << 30);

   // Configuration registers.
   logic [31:0]    sample_period_ff;
   logic [1:0]     num_order_ff, den_order_ff;
   logic [63:0]    num_coeffs_ff, den_coeffs_ff;

   // Sequencer.
   logic [3:0]     state_ff, state_in;
   logic [1:0]     k_ff, k_in;
   logic [2:0]     sub_ff, sub_in;

   // Working values.
   logic [31:0]             omega_ff;
   logic [63:0]             p_ff;
   logic [31:0]             lohi_ff;
   logic signed [MUL_W-1:0] pr_ff [4];
   logic signed [MUL_W-1:0] pim_ff [4];
   logic signed [MUL_W-1:0] sum_ff [4];
   logic [ACC_W-1:0]        mag2_ff;
   logic signed [ACC_W-1:0] re_ff, im_ff;
   logic                    sing_ff;

   // Response register.
   logic                    rsp_valid_ff;
   logic signed [31:0]      rsp_real_ff, rsp_imag_ff;
   logic                    rsp_sing_ff;

   mac_op_type              mac_op;
   logic signed [MUL_W-1:0] mac_a, mac_b;
   logic signed [ACC_W-1:0] mac_acc;
   logic                    cordic_start, cordic_busy;
   logic signed [MUL_W-1:0] zr, zi;
   logic                    div_start, div_re_busy, div_im_busy;
   logic [31:0]             quot_re, quot_im;
   logic [31:0]             ang;
   logic [1:0]              nb, na, km1;
   logic                    use_k, accept, out_free, load_out;
   logic [COEF_W-1:0]       coef_raw;
   logic signed [MUL_W-1:0] coef;

   assign accept   = req.valid && req.ready;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign load_out = (state_ff == S_DONE) && out_free;
   assign nb  = (num_order_ff > ORD_MAX) ? ORD_MAX : num_order_ff;
   assign na  = (den_order_ff > ORD_MAX) ? ORD_MAX : den_order_ff;
   assign km1 = k_ff - 2'd1;

   // The phase in turns is the top PHASE_BITS of the 48-bit fraction of omega*Ts/(2*pi).
   assign ang = {mac_acc[47 -: PHASE_BITS], (32 - PHASE_BITS)'(0)};

   // In the sums, sub_ff selects real/imaginary by bit 0 and numerator/denominator by bit 1.
   assign coef_raw = sub_ff[1] ? den_coeffs_ff[{k_ff, 4'b0} +: COEF_W]
                               : num_coeffs_ff[{k_ff, 4'b0} +: COEF_W];
   assign use_k    = sub_ff[1] ? (k_ff <= na) : (k_ff <= nb);
   assign coef     = use_k ? MUL_W'(signed'(coef_raw)) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_period_ff <= '0;
         num_order_ff     <= 2'd0;
         den_order_ff     <= 2'd1;
         num_coeffs_ff    <= '0;
         den_coeffs_ff    <= 64'd8192;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_wdata[31:0];
            CSR_NUM_ORDER:     num_order_ff     <= csr_wdata[1:0];
            CSR_DEN_ORDER:     den_order_ff     <= csr_wdata[1:0];
            CSR_NUM_COEFFS:    num_coeffs_ff    <= csr_wdata;
            CSR_DEN_COEFFS:    den_coeffs_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Operand selection for the shared multiply-accumulate unit.
   always_comb begin
      mac_op = '{first: 1'b1, neg: 1'b0, init: '0};
      mac_a  = '0;
      mac_b  = '0;
      case (state_ff)
         S_PHASE: begin
            case (sub_ff)
               3'd0: begin
                  mac_a = MUL_W'(omega_ff);
                  mac_b = MUL_W'(sample_period_ff);
               end
               3'd1: begin
                  mac_a = MUL_W'(p_ff[31:0]);
                  mac_b = MUL_W'(INV2PI_Q32);
               end
               default: begin
                  mac_a       = MUL_W'(p_ff[63:32]);
                  mac_b       = MUL_W'(INV2PI_Q32);
                  mac_op.init = ACC_W'(lohi_ff);
               end
            endcase
         end
         S_POW: begin
            case (sub_ff)
               3'd0: begin
                  mac_a = pr_ff[km1]; mac_b = zr; mac_op.init = ROUND_POW;
               end
               3'd1: begin
                  mac_a = pim_ff[km1]; mac_b = zi;
                  mac_op.first = 1'b0; mac_op.neg = 1'b1;
               end
               3'd2: begin
                  mac_a = pr_ff[km1]; mac_b = zi; mac_op.init = ROUND_POW;
               end
               default: begin
                  mac_a = pim_ff[km1]; mac_b = zr; mac_op.first = 1'b0;
               end
            endcase
         end
         S_SUM: begin
            mac_a        = coef;
            mac_b        = sub_ff[0] ? pim_ff[k_ff] : pr_ff[k_ff];
            mac_op.first = (k_ff == 2'd0);
            mac_op.init  = ROUND_SUM;
         end
         S_FIN: begin
            // sum_ff holds nr, ni, dr, di in that order.
            case (sub_ff)
               3'd0: begin mac_a = sum_ff[2]; mac_b = sum_ff[2]; end
               3'd1: begin mac_a = sum_ff[3]; mac_b = sum_ff[3]; mac_op.first = 1'b0; end
               3'd2: begin mac_a = sum_ff[0]; mac_b = sum_ff[2]; end
               3'd3: begin mac_a = sum_ff[1]; mac_b = sum_ff[3]; mac_op.first = 1'b0; end
               3'd4: begin mac_a = sum_ff[1]; mac_b = sum_ff[2]; end
               default: begin
                  mac_a = sum_ff[0]; mac_b = sum_ff[3];
                  mac_op.first = 1'b0; mac_op.neg = 1'b1;
               end
            endcase
         end
         default: ;
      endcase
   end

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      sub_in       = sub_ff;
      cordic_start = 1'b0;
      div_start    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_PHASE;
               sub_in   = 3'd0;
            end
         end
         S_PHASE: begin
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd2) begin
               cordic_start = 1'b1;
               state_in     = S_CORDIC;
            end
         end
         S_CORDIC: begin
            if (!cordic_busy) begin
               state_in = S_POW;
               k_in     = 2'd1;
               sub_in   = 3'd0;
            end
         end
         S_POW: begin
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd3) begin
               sub_in = 3'd0;
               if (k_ff == ORD_MAX) begin
                  state_in = S_SUM;
                  k_in     = 2'd0;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         S_SUM: begin
            k_in = k_ff + 2'd1;
            if (k_ff == ORD_MAX) begin
               k_in   = 2'd0;
               sub_in = sub_ff + 3'd1;
               if (sub_ff == 3'd3) begin
                  state_in = S_FIN;
                  sub_in   = 3'd0;
               end
            end
         end
         S_FIN: begin
            sub_in = sub_ff + 3'd1;
            if (sub_ff == 3'd5) begin
               state_in = S_DSTART;
            end
         end
         S_DSTART: begin
            if (mag2_ff == '0) begin
               state_in = S_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (!div_re_busy && !div_im_busy) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         k_ff     <= '0;
         sub_ff   <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         sub_ff   <= sub_in;
      end
   end

   // Working registers written from the accumulator as each product chain closes.
   always_ff @(posedge clock) begin
      if (accept) begin
         omega_ff  <= req.omega;
         pr_ff[0]  <= ONE_Q30;
         pim_ff[0] <= '0;
      end
      if (state_ff == S_PHASE && sub_ff == 3'd0) begin
         p_ff <= mac_acc[63:0];
      end
      if (state_ff == S_PHASE && sub_ff == 3'd1) begin
         lohi_ff <= mac_acc[63:32];
      end
      if (state_ff == S_POW && sub_ff == 3'd1) begin
         pr_ff[k_ff] <= MUL_W'(mac_acc >>> 30);
      end
      if (state_ff == S_POW && sub_ff == 3'd3) begin
         pim_ff[k_ff] <= MUL_W'(mac_acc >>> 30);
      end
      if (state_ff == S_SUM && k_ff == ORD_MAX) begin
         sum_ff[sub_ff[1:0]] <= MUL_W'(mac_acc >>> 19);
      end
      if (state_ff == S_FIN && sub_ff == 3'd1) begin
         mag2_ff <= mac_acc;
      end
      if (state_ff == S_FIN && sub_ff == 3'd3) begin
         re_ff <= mac_acc;
      end
      if (state_ff == S_FIN && sub_ff == 3'd5) begin
         im_ff <= mac_acc;
      end
      if (state_ff == S_DSTART) begin
         sing_ff <= (mag2_ff == '0);
      end
   end

   // Response register: loads when the item finishes and the previous beat has gone.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_real_ff <= sing_ff ? '0 : quot_re;
         rsp_imag_ff <= sing_ff ? '0 : quot_im;
         rsp_sing_ff <= sing_ff;
      end
   end

   assign req.ready     = (state_ff == S_IDLE);
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.resp_real = rsp_real_ff;
   assign rsp.resp_imag = rsp_imag_ff;
   assign rsp.singular  = rsp_sing_ff;

   rfre_mac u_mac (
      .clock  (clock),
      .op     (mac_op),
      .a      (mac_a),
      .b      (mac_b),
      .acc_in (mac_acc)
   );

   rfre_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .ang   (ang),
      .busy  (cordic_busy),
      .zr    (zr),
      .zi    (zi)
   );

   rfre_div u_div_re (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (re_ff),
      .den   (mag2_ff),
      .busy  (div_re_busy),
      .quot  (quot_re)
   );

   rfre_div u_div_im (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (im_ff),
      .den   (mag2_ff),
      .busy  (div_im_busy),
      .quot  (quot_im)
   );
endmodule

@@ sv/rfre_checker.sv @@
// Port-level checks of the frequency response core, bound to its top level.
// Depends on rational_frequency_response_eval_core_assert.svh.
`include "rational_frequency_response_eval_core_assert.svh"

module rfre_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_real,
   input logic [31:0] rsp_imag,
   input logic        rsp_singular
);
   // One item at a time: a taken request closes the request side.
   `RFRE_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)

   // A singular response carries zero in both parts.
   `RFRE_ASSERT_SAME(a_singular_zero, rsp_valid && rsp_singular,
                     rsp_real == 32'd0 && rsp_imag == 32'd0)

   // A stalled response beat holds its payload.
   `RFRE_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_real) && $stable(rsp_imag) && $stable(rsp_singular))
endmodule

bind rational_frequency_response_eval_core rfre_checker u_rfre_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req.valid),
   .req_ready    (req.ready),
   .rsp_valid    (rsp.valid),
   .rsp_ready    (rsp.ready),
   .rsp_real     (rsp.resp_real),
   .rsp_imag     (rsp.resp_imag),
   .rsp_singular (rsp.singular)
);
